FILE: hdl/swm_pkg.sv
// Shared constants, types and the cell control bundle for the sliding window maximum.
// No dependencies; every other file of the block imports this package.
package swm_pkg;

   localparam int MAX_WINDOW       = 16;
   localparam int SAMPLE_WIDTH     = 16;
   localparam int WINDOW_REG_WIDTH = 5;
   localparam int COUNT_WIDTH      = $clog2(MAX_WINDOW + 1);
   localparam int CMP_WIDTH        =
      (COUNT_WIDTH > WINDOW_REG_WIDTH) ? COUNT_WIDTH : WINDOW_REG_WIDTH;

   typedef logic signed [SAMPLE_WIDTH-1:0]     sample_type;
   typedef logic        [WINDOW_REG_WIDTH-1:0] window_type;
   typedef logic        [COUNT_WIDTH-1:0]      count_type;
   typedef logic        [CMP_WIDTH-1:0]        cmp_type;

   typedef struct packed {
      logic load;
      logic advance;
   } swm_cell_ctl_type;

endpackage

FILE: hdl/swm_if.sv
// Valid/ready channel interfaces for samples, results and the window size register.
// Depends on swm_pkg for the payload types.
interface swm_req_if
   import swm_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       first;

   modport source (output valid, output sample, output first, input ready);
   modport sink   (input valid, input sample, input first, output ready);
endinterface

interface swm_rsp_if
   import swm_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_csr_if
   import swm_pkg::*;
   ();
   logic       valid;
   logic       ready;
   window_type window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

FILE: hdl/swm_cell.sv
// One cell of the window chain: a stored sample, a token bit and a running maximum.
// Depends on swm_pkg for the sample type and the control bundle.
module swm_cell
   import swm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  swm_cell_ctl_type ctl,
   input  logic             in_window,
   input  sample_type       sample_in,
   input  logic             token_in,
   input  sample_type       acc_in,
   output sample_type       sample_out,
   output logic             token_out,
   output sample_type       acc_out
);

   sample_type sample_ff;
   sample_type acc_ff;
   sample_type acc_in_sel;
   logic       token_ff;

   // The running maximum only picks up this cell's sample when it lies inside the window.
   always_comb begin
      acc_in_sel = acc_in;
      if (in_window && (sample_ff > acc_in)) begin
         acc_in_sel = sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sample_ff <= sample_in;
         acc_ff    <= sample_in;
      end else if (ctl.advance && token_in) begin
         acc_ff <= acc_in_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else if (ctl.load || ctl.advance) begin
         token_ff <= token_in;
      end
   end

   assign sample_out = sample_ff;
   assign token_out  = token_ff;
   assign acc_out    = acc_ff;

endmodule

FILE: hdl/sliding_window_max.sv
// Sliding window maximum over a chain of MAX_WINDOW cells; depends on swm_pkg, swm_if, swm_cell.
// rsp.valid rises once the sample's token has walked every cell of the chain and its result is registered.
// One sample is in flight at a time: the next is taken only as the token leaves the end of the chain.
// A waiting result does not block the next sample until that sample's own result is due.
// Reset clears the fill count, the tokens and the output valid; window_size returns to 1.
module sliding_window_max
   import swm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   swm_req_if.sink   req,
   swm_rsp_if.source rsp,
   swm_csr_if.sink   csr
);

   window_type window_ff;
   count_type  fill_ff;
   count_type  fill_in;
   count_type  fill_base;
   logic       busy_ff;
   logic       emit_ff;
   logic       emit_in;
   logic       rsp_valid_ff;
   sample_type rsp_data_ff;
   cmp_type    win_eff;
   logic       load;
   logic       advance;
   logic       complete;

   swm_cell_ctl_type ctl;

   sample_type sample_vec [MAX_WINDOW];
   sample_type acc_vec    [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] token_vec;
   logic [MAX_WINDOW-1:0] include_vec;

   // Window size zero acts as one; sizes beyond the chain saturate at its length.
   always_comb begin
      win_eff = CMP_WIDTH'(window_ff);
      if (window_ff == '0) begin
         win_eff = CMP_WIDTH'(1);
      end else if (CMP_WIDTH'(window_ff) > CMP_WIDTH'(MAX_WINDOW)) begin
         win_eff = CMP_WIDTH'(MAX_WINDOW);
      end
   end

   // The chain freezes only while its finished result cannot enter the output register.
   assign advance  = !(token_vec[MAX_WINDOW-1] && rsp_valid_ff && !rsp.ready);
   assign complete = token_vec[MAX_WINDOW-1] && advance;
   assign req.ready = !busy_ff || complete;
   assign load      = req.valid && req.ready;
   assign ctl       = '{load: load, advance: advance};

   always_comb begin
      fill_base = req.first ? '0 : fill_ff;
      fill_in   = fill_base;
      if (fill_base < COUNT_WIDTH'(MAX_WINDOW)) begin
         fill_in = fill_base + COUNT_WIDTH'(1);
      end
      emit_in = (CMP_WIDTH'(fill_in) >= win_eff);
   end

   genvar k;
   generate
      for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
         assign include_vec[k] = (CMP_WIDTH'(k) < win_eff);
         if (k == 0) begin : g_head
            swm_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .in_window  (include_vec[k]),
               .sample_in  (req.sample),
               .token_in   (load),
               .acc_in     (req.sample),
               .sample_out (sample_vec[k]),
               .token_out  (token_vec[k]),
               .acc_out    (acc_vec[k])
            );
         end else begin : g_body
            swm_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .in_window  (include_vec[k]),
               .sample_in  (sample_vec[k-1]),
               .token_in   (token_vec[k-1]),
               .acc_in     (acc_vec[k-1]),
               .sample_out (sample_vec[k]),
               .token_out  (token_vec[k]),
               .acc_out    (acc_vec[k])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= window_type'(1);
         fill_ff      <= '0;
         busy_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            window_ff <= csr.window_size;
         end
         if (load) begin
            fill_ff <= fill_in;
            emit_ff <= emit_in;
            busy_ff <= 1'b1;
         end else if (complete) begin
            busy_ff <= 1'b0;
         end
         if (complete && emit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (complete && emit_ff) begin
         rsp_data_ff <= acc_vec[MAX_WINDOW-1];
      end
   end

   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.window_max = rsp_data_ff;

   // At most one sample is in flight, and the busy flag follows its token.
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one token in the cell chain");

   a_busy_token : assert property (@(posedge clock) disable iff (reset)
      busy_ff == (|token_vec))
      else $error("busy flag disagrees with the token in the chain");

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      token_vec[MAX_WINDOW-1] && rsp_valid_ff && !rsp.ready |=> token_vec[MAX_WINDOW-1])
      else $error("finished transaction left the chain while the output was stalled");

   a_fill_range : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_WIDTH'(MAX_WINDOW))
      else $error("fill count exceeds the chain length");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for sliding_window_max: drives sample transactions and window size
// writes, predicts every window maximum and checks each result transaction in order.
// Depends on swm_pkg and the channel interfaces in swm_if.
module testbench
   import swm_pkg::*;
();

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_TICKS = 2 * MAX_WINDOW + 4;

   logic clock;
   logic reset;

   swm_req_if req_ch ();
   swm_rsp_if rsp_ch ();
   swm_csr_if csr_ch ();

   sliding_window_max u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Predictor state: newest sample at index 0, count of samples in the current sequence.
   sample_type recent_samples [MAX_WINDOW];
   int         seq_count;
   window_type window_reg;
   sample_type expected_max [$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_left;
   int mismatch_count;
   int cycle_count;

   always #6 clock = ~clock;

   function automatic void track_window_max(input sample_type s, input logic f);
      int         span;
      sample_type best;
      if (f)
         seq_count = 0;
      for (int i = MAX_WINDOW - 1; i > 0; i--)
         recent_samples[i] = recent_samples[i-1];
      recent_samples[0] = s;
      if (seq_count < MAX_WINDOW)
         seq_count++;
      if (window_reg == 0)
         span = 1;
      else if (window_reg > MAX_WINDOW)
         span = MAX_WINDOW;
      else
         span = window_reg;
      if (seq_count >= span) begin
         best = recent_samples[0];
         for (int i = 1; i < span; i++)
            if (recent_samples[i] > best)
               best = recent_samples[i];
         expected_max = {expected_max, best};
      end
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic window_type pick_window();
      case ($urandom_range(7))
         0:       return window_type'(0);
         1:       return window_type'(1);
         2:       return window_type'(MAX_WINDOW);
         3:       return window_type'(31);
         4:       return window_type'(MAX_WINDOW + 1);
         default: return window_type'($urandom_range(31));
      endcase
   endfunction

   task automatic send_sample(input sample_type s, input logic f);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      req_ch.first  <= f;
      do @(posedge clock); while (!req_ch.ready);
      track_window_max(s, f);
   endtask

   task automatic stop_samples();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Waits for every expected result, then lets any sample that yields none leave the chain.
   task automatic drain();
      while (expected_max.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_window(input window_type w);
      @(negedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.window_size <= w;
      do @(posedge clock); while (!csr_ch.ready);
      window_reg = w;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_window_edges();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_window(window_type'(1));
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shFFFF, 1'b0);
      stop_samples();
      drain();
      write_window(window_type'(3));
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(-16'sd5, 1'b0);
      send_sample(-16'sd7, 1'b0);
      send_sample(-16'sd9, 1'b0);
      // A first flag mid-stream restarts the count, so two samples pass without a result.
      send_sample(16'sd100, 1'b1);
      send_sample(-16'sd100, 1'b0);
      send_sample(16'sd7, 1'b0);
      stop_samples();
      drain();
      // Growing the window beyond the count holds results back until the count catches up.
      write_window(window_type'(5));
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd2, 1'b0);
      stop_samples();
      drain();
      // A window of zero behaves as a window of one.
      write_window(window_type'(0));
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b0);
      stop_samples();
      drain();
   endtask

   task automatic test_random_streams(input int send_pct, input int recv_pct,
                                      input window_type start_window, input int items);
      int sent;
      int since_write;
      int seq_len;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent           = 0;
      since_write    = 0;
      write_window(start_window);
      while (sent < items) begin
         if (since_write > 120) begin
            stop_samples();
            drain();
            write_window(pick_window());
            since_write = 0;
         end
         seq_len = $urandom_range(1, 48);
         for (int k = 0; k < seq_len; k++)
            send_sample(pick_sample(), (k == 0) || ($urandom_range(19) == 0));
         sent        += seq_len;
         since_write += seq_len;
      end
      stop_samples();
      drain();
   endtask

   // The receiver refuses results for a long stretch while samples keep coming, so the
   // block fills up and has to stall its input.
   task automatic test_output_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 10;
      write_window(window_type'(1));
      hold_off_left = 400;
      for (int k = 0; k < 60; k++)
         send_sample(pick_sample(), k == 0);
      stop_samples();
      drain();
   endtask

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_max.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result transaction, expected none, actual %0d",
                     $time, rsp_ch.window_max);
         end else if (rsp_ch.window_max !== expected_max[0]) begin
            mismatch_count++;
            $display("%0t: window_max mismatch, expected %0d, actual %0d",
                     $time, expected_max[0], rsp_ch.window_max);
            void'(expected_max.pop_front());
         end else begin
            void'(expected_max.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped at the cycle limit", $time);
         $display("sliding_window_max test failed");
         $finish;
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.first       = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.window_size = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_off_left      = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      seq_count          = 0;
      window_reg         = window_type'(1);
      foreach (recent_samples[i])
         recent_samples[i] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_window_edges();
      test_random_streams(0, 0, window_type'(MAX_WINDOW), 250);
      test_random_streams(67, 0, window_type'(31), 250);
      test_random_streams(0, 67, pick_window(), 250);
      test_random_streams(22, 22, pick_window(), 250);
      test_output_hold_off();

      if (mismatch_count == 0 && expected_max.size() == 0)
         $display("sliding_window_max test passed");
      else
         $display("sliding_window_max test failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/swm_pkg.sv
hdl/swm_if.sv
hdl/swm_cell.sv
hdl/sliding_window_max.sv
tb/testbench.sv
